>>> sv/rbst_pkg.sv
// shared types, constants and compare helpers for the ray/box slab test
package rbst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    // bound - origin + offset stays exact in this many signed bits
    localparam int DIFF_W    = COORD_W + 2;
    // the difference is split into a low unsigned part and a high signed part
    localparam int LO_W      = DIFF_W / 2;
    localparam int HI_W      = DIFF_W - LO_W;
    localparam int PL_W      = COORD_W + LO_W + 1;
    localparam int PH_W      = COORD_W + HI_W;
    // full-width slab parameter, 2*FRAC_BITS fraction bits
    localparam int T_W       = COORD_W + DIFF_W;
    localparam int TENTH     = ((1 << FRAC_BITS) + 5) / 10;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int NUM_AXES  = 3;
    localparam int NUM_T     = 2 * NUM_AXES;
    localparam int IDX_W     = 3;

    localparam int IN_DATA_W  = NUM_T * COORD_W;
    localparam int OUT_DATA_W = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PL_W-1:0]    plo_t;
    typedef logic signed [PH_W-1:0]    phi_t;
    typedef logic signed [T_W-1:0]     tval_t;

    typedef enum logic [IDX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_INV_DIR_X = 3'd3,
        REG_INV_DIR_Y = 3'd4,
        REG_INV_DIR_Z = 3'd5
    } reg_idx_t;

    // ray held in configuration
    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t inv_dir_x;
        coord_t inv_dir_y;
        coord_t inv_dir_z;
    } ray_t;

    function automatic tval_t t_min(tval_t a, tval_t b);
        return (b < a) ? b : a;
    endfunction

    function automatic tval_t t_max(tval_t a, tval_t b);
        return (a < b) ? b : a;
    endfunction

endpackage

>>> sv/rbst_slab.sv
// slab parameter pipeline: differences, split products, product sum
module rbst_slab (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rbst_pkg::ray_t          ray,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rbst_pkg::coord_t        bound [rbst_pkg::NUM_T],
    output logic                    out_valid,
    input  logic                    out_ready,
    output rbst_pkg::tval_t         t_out [rbst_pkg::NUM_T]
);
    import rbst_pkg::*;

    localparam int NST = 3;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    coord_t org [NUM_AXES];
    coord_t inv [NUM_AXES];

    diff_t  d_next  [NUM_T];
    diff_t  d_reg   [NUM_T];
    plo_t   pl_next [NUM_T];
    plo_t   pl_reg  [NUM_T];
    phi_t   ph_next [NUM_T];
    phi_t   ph_reg  [NUM_T];
    tval_t  t_next  [NUM_T];
    tval_t  t_reg   [NUM_T];

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign inv[0] = ray.inv_dir_x;
    assign inv[1] = ray.inv_dir_y;
    assign inv[2] = ray.inv_dir_z;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    // stage 1: differences, flat or inverted boxes get the offset on max
    always_comb
    begin
        diff_t lo;
        diff_t hi;
        diff_t og;
        diff_t ext;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            lo  = DIFF_W'(bound[2*a]);
            hi  = DIFF_W'(bound[2*a+1]);
            og  = DIFF_W'(org[a]);
            ext = hi - lo;
            d_next[2*a]   = lo - og;
            d_next[2*a+1] = hi - og + ((ext > 0) ? diff_t'(0) : diff_t'(TENTH));
        end
    end

    // stage 2: two partial products per parameter
    always_comb
    begin
        logic signed [LO_W:0]   dl;
        logic signed [HI_W-1:0] dh;
        for (int i = 0; i < NUM_T; i++)
        begin
            dl = $signed({1'b0, d_reg[i][LO_W-1:0]});
            dh = $signed(d_reg[i][DIFF_W-1:LO_W]);
            pl_next[i] = PL_W'(inv[i/2]) * PL_W'(dl);
            ph_next[i] = PH_W'(inv[i/2]) * PH_W'(dh);
        end
    end

    // stage 3: recombine into the full product
    always_comb
    begin
        for (int i = 0; i < NUM_T; i++)
        begin
            t_next[i] = (T_W'(ph_reg[i]) <<< LO_W) + T_W'(pl_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_T; i++)
        begin
            if (en[0])
            begin
                d_reg[i] <= d_next[i];
            end
            if (en[1])
            begin
                pl_reg[i] <= pl_next[i];
                ph_reg[i] <= ph_next[i];
            end
            if (en[2])
            begin
                t_reg[i] <= t_next[i];
            end
        end
    end

    assign t_out = t_reg;

endmodule

>>> sv/rbst_fold.sv
// entry/exit fold over the three axes and the final hit compare
module rbst_fold (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rbst_pkg::tval_t         t_in [rbst_pkg::NUM_T],
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit
);
    import rbst_pkg::*;

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    // stage 1 results
    tval_t xmn_reg, xmx_reg, ymn_reg, ymx_reg, zmn_reg, zmx_reg;
    // stage 2: entry after y
    tval_t tmin1_reg, xmx2_reg, ymx2_reg, zmn2_reg, zmx2_reg;
    // stage 3: exit after y
    tval_t tmin1b_reg, tmax1_reg, zmn3_reg, zmx3_reg;
    // stage 4: entry after z
    tval_t tmin2_reg, tmax1b_reg, zmx4_reg;
    // stage 5: exit after z
    tval_t tmin2b_reg, tmax2_reg;
    // stage 6: output register
    logic  hit_reg;

    tval_t tmin1_next, tmax1_next, tmin2_next, tmax2_next;
    logic  hit_next;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign hit       = hit_reg;

    // clamped fold order, each exit uses the freshly updated entry
    assign tmin1_next = t_max(xmn_reg, t_min(ymn_reg, xmx_reg));
    assign tmax1_next = t_min(xmx2_reg, t_max(ymx2_reg, tmin1_reg));
    assign tmin2_next = t_max(tmin1b_reg, t_min(zmn3_reg, tmax1_reg));
    assign tmax2_next = t_min(tmax1b_reg, t_max(zmx4_reg, tmin2_reg));
    assign hit_next   = t_max(tmin2b_reg, tval_t'(0)) < tmax2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xmn_reg <= t_min(t_in[0], t_in[1]);
            xmx_reg <= t_max(t_in[0], t_in[1]);
            ymn_reg <= t_min(t_in[2], t_in[3]);
            ymx_reg <= t_max(t_in[2], t_in[3]);
            zmn_reg <= t_min(t_in[4], t_in[5]);
            zmx_reg <= t_max(t_in[4], t_in[5]);
        end
        if (en[1])
        begin
            tmin1_reg <= tmin1_next;
            xmx2_reg  <= xmx_reg;
            ymx2_reg  <= ymx_reg;
            zmn2_reg  <= zmn_reg;
            zmx2_reg  <= zmx_reg;
        end
        if (en[2])
        begin
            tmin1b_reg <= tmin1_reg;
            tmax1_reg  <= tmax1_next;
            zmn3_reg   <= zmn2_reg;
            zmx3_reg   <= zmx2_reg;
        end
        if (en[3])
        begin
            tmin2_reg  <= tmin2_next;
            tmax1b_reg <= tmax1_reg;
            zmx4_reg   <= zmx3_reg;
        end
        if (en[4])
        begin
            tmin2b_reg <= tmin2_reg;
            tmax2_reg  <= tmax2_next;
        end
        if (en[5])
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

>>> sv/ray_box_slab_test.sv
// a box item gives its hit item through 3 product stages and 6 compare stages;
// throughput: one item per cycle while the sink takes every item, set by the compare chain
// being cut into single-step stages and each stage holding its own valid bit
// reset: rst_n clears all stage valid bits, origin resets to zero and the inverse
// direction registers to 1.0
module ray_box_slab_test (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbst_pkg::IDX_W-1:0]        cfg_index,
    input  logic [rbst_pkg::COORD_W-1:0]      cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x_min, x_max, y_min, y_max, z_min, z_max
    input  logic [rbst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hit, then zero fill
    output logic [rbst_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import rbst_pkg::*;

    ray_t   ray_reg;
    coord_t bound [NUM_T];
    tval_t  t_val [NUM_T];
    logic   slab_valid;
    logic   fold_ready;
    logic   hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_reg.origin_x  <= '0;
            ray_reg.origin_y  <= '0;
            ray_reg.origin_z  <= '0;
            ray_reg.inv_dir_x <= coord_t'(ONE);
            ray_reg.inv_dir_y <= coord_t'(ONE);
            ray_reg.inv_dir_z <= coord_t'(ONE);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ORIGIN_X:  ray_reg.origin_x  <= cfg_data;
                REG_ORIGIN_Y:  ray_reg.origin_y  <= cfg_data;
                REG_ORIGIN_Z:  ray_reg.origin_z  <= cfg_data;
                REG_INV_DIR_X: ray_reg.inv_dir_x <= cfg_data;
                REG_INV_DIR_Y: ray_reg.inv_dir_y <= cfg_data;
                REG_INV_DIR_Z: ray_reg.inv_dir_z <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_T; i++)
        begin
            bound[i] = s_axis_tdata[i*COORD_W +: COORD_W];
        end
    end

    rbst_slab u_slab (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .bound     (bound),
        .out_valid (slab_valid),
        .out_ready (fold_ready),
        .t_out     (t_val)
    );

    rbst_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slab_valid),
        .in_ready  (fold_ready),
        .t_in      (t_val),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .hit       (hit)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-1){1'b0}}, hit};

    // the fold only stalls when its output item is held by the sink
    a_fold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !fold_ready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("fold stage stalled without a held output item");

    // input back-pressure only comes from a full slab pipe facing a stalled fold
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (slab_valid && !fold_ready))
        else $error("input stalled while the slab pipe could move");

    // a sink that takes every item never stalls the source
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

endmodule
